@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is asserted.
`define HK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define HK_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/hk4_pkg.sv @@
// ----------------------------------------------------------------------------
// hk4_pkg
// Types and constants for the 4-D Hilbert key encoder.
// ----------------------------------------------------------------------------
package hk4_pkg;

	localparam int unsigned AXES    = 4;
	localparam int unsigned BITS    = 32;
	localparam int unsigned KEY_W   = AXES * BITS;
	localparam int unsigned HALF_W  = KEY_W / 2;
	// one cell for each bit level from the top down to bit 1
	localparam int unsigned LEVELS  = BITS - 1;
	// cells plus the Gray/fix-up output stage
	localparam int unsigned LATENCY = LEVELS + 1;

	typedef logic [BITS-1:0] coord_t;
	typedef coord_t [AXES-1:0] axis_vec_t;

	typedef struct packed {
		logic [BITS-1:0] coord_x;
		logic [BITS-1:0] coord_y;
		logic [BITS-1:0] coord_z;
		logic [BITS-1:0] coord_w;
	} point_t;

	typedef struct packed {
		logic [HALF_W-1:0] key_upper;
		logic [HALF_W-1:0] key_lower;
	} key_t;

endpackage

@@ hw/rtl/hk4_cell.sv @@
// ----------------------------------------------------------------------------
// hk4_cell
// One bit level of the inverse undo pass; registers the axis vector.
// ----------------------------------------------------------------------------
module hk4_cell import hk4_pkg::*; #(
	parameter int unsigned LEVEL = BITS - 1
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      vld_in,
	input  axis_vec_t v_in,
	output logic      vld_q,
	output axis_vec_t v_q
);

	localparam coord_t LOW_MASK = coord_t'((64'(1) << LEVEL) - 64'(1));

	axis_vec_t v_d;

	always_comb begin
		coord_t t;
		t   = '0;
		v_d = v_in;
		// axes go in order; axis 0 may change at every step
		for (int a = 0; a < AXES; a++) begin
			if (v_d[a][LEVEL]) begin
				v_d[0] = v_d[0] ^ LOW_MASK;
			end else begin
				t      = (v_d[0] ^ v_d[a]) & LOW_MASK;
				v_d[0] = v_d[0] ^ t;
				v_d[a] = v_d[a] ^ t;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		v_q <= v_d;
	end

endmodule

@@ hw/rtl/hk4_finish.sv @@
// ----------------------------------------------------------------------------
// hk4_finish
// Gray encode across the axes, fix-up XOR and bit interleave into the key.
// ----------------------------------------------------------------------------
module hk4_finish import hk4_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      vld_in,
	input  axis_vec_t v_in,
	output logic      done_q,
	output key_t      key_q
);

	axis_vec_t         g;
	coord_t            fix;
	logic [KEY_W-1:0]  key_d;

	always_comb begin
		coord_t tail;
		g[0] = v_in[0];
		for (int a = 1; a < AXES; a++) begin
			g[a] = v_in[a] ^ g[a-1];
		end
		// fix bit j is the parity of the last axis above bit j
		for (int j = 0; j < BITS; j++) begin
			tail   = g[AXES-1] >> (j + 1);
			fix[j] = ^tail;
		end
		for (int b = 0; b < BITS; b++) begin
			for (int a = 0; a < AXES; a++) begin
				key_d[AXES*b + AXES - 1 - a] = g[a][b] ^ fix[b];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		key_q.key_upper <= key_d[KEY_W-1:HALF_W];
		key_q.key_lower <= key_d[HALF_W-1:0];
	end

endmodule

@@ hw/rtl/hilbert_4d_key_encoder.sv @@
// A point transferred on start comes out as its key with done at the end of the pipeline.
// Throughput: one point per cycle; busy stays low, the cell chain never stalls.
// The pipeline is the row of 31 bit-level cells plus one output stage.
// The receiver cannot hold results off; each key shows for one cycle.
// Reset clears the valid bits of the chain; data registers are not reset.
// ----------------------------------------------------------------------------
// hilbert_4d_key_encoder
// Pipelined 4-D Hilbert curve key encoder, 32 bits per axis, 128-bit key.
// ----------------------------------------------------------------------------
module hilbert_4d_key_encoder import hk4_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  point_t point,
	output logic   done,
	output key_t   key
);

	logic      chain_vld [0:LEVELS];
	axis_vec_t chain_v   [0:LEVELS];

	assign busy = 1'b0;

	assign chain_vld[0]  = start;
	assign chain_v[0][0] = point.coord_x;
	assign chain_v[0][1] = point.coord_y;
	assign chain_v[0][2] = point.coord_z;
	assign chain_v[0][3] = point.coord_w;

	for (genvar i = 0; i < LEVELS; i++) begin : g_cell
		hk4_cell #(
			.LEVEL (BITS - 1 - i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_in (chain_vld[i]),
			.v_in   (chain_v[i]),
			.vld_q  (chain_vld[i+1]),
			.v_q    (chain_v[i+1])
		);
	end

	hk4_finish u_finish (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_in (chain_vld[LEVELS]),
		.v_in   (chain_v[LEVELS]),
		.done_q (done),
		.key_q  (key)
	);

endmodule

@@ hw/rtl/hk4_checker.sv @@
// ----------------------------------------------------------------------------
// hk4_checker
// Port-level checks of the Hilbert key encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hk4_checker import hk4_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   start,
	input logic   busy,
	input point_t point,
	input logic   done,
	input key_t   key
);

	logic take;
	assign take = start && !busy;

	`HK_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")
	`HK_ASSERT(a_done_after_take, take |-> ##LATENCY done, "key missing after transfer")
	`HK_ASSERT(a_no_spurious_done, done |-> $past(take, LATENCY), "done without transfer")
	`HK_ASSERT(a_origin_key, (take && point == '0) |-> ##LATENCY (key == '0), "origin key not zero")

endmodule

bind hilbert_4d_key_encoder hk4_checker u_hk4_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.point  (point),
	.done   (done),
	.key    (key)
);
